// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked on every edge, reset included
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CHK(label, prop, msg)
`define ASSERT_ALL(label, prop, msg)
`endif
`endif

// File: rtl/cll_pkg.sv
package cll_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_WORD,
    MODE_SYM
  } mode_t;

  localparam logic [3:0] CLS_KEYWORD   = 4'd0;
  localparam logic [3:0] CLS_IDENT     = 4'd1;
  localparam logic [3:0] CLS_ARITH     = 4'd2;
  localparam logic [3:0] CLS_BRACKET   = 4'd3;
  localparam logic [3:0] CLS_NUMBER    = 4'd4;
  localparam logic [3:0] CLS_RELATION  = 4'd5;
  localparam logic [3:0] CLS_SEPARATOR = 4'd6;
  localparam logic [3:0] CLS_ERROR     = 4'd7;
  localparam logic [3:0] CLS_LOGICAL   = 4'd8;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int QUEUE_DEPTH = 4;

  localparam int KW_COUNT = 12;

  // do end for if printf scanf then while return int void begin
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h6F64,
    64'h646E65,
    64'h726F66,
    64'h6669,
    64'h66746E697270,
    64'h666E616373,
    64'h6E656874,
    64'h656C696877,
    64'h6E7275746572,
    64'h746E69,
    64'h64696F76,
    64'h6E69676562
  };

  typedef struct packed {
    logic [3:0]  tclass;
    logic [3:0]  kw;
    logic [63:0] text;
    logic [5:0]  len;
    logic        too_long;
    logic [15:0] line;
    logic [15:0] pos;
    logic        last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "$");
  endfunction

  // bytes that may open a two-byte operator
  function automatic logic is_sym_start(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "<") || (c == ">") ||
           (c == "!") || (c == "&") || (c == "|");
  endfunction

  function automatic logic [3:0] single_class(input logic [7:0] c);
    logic [3:0] r;
    case (c) inside
      "+", "-", "*", "/":           r = CLS_ARITH;
      "<", ">":                     r = CLS_RELATION;
      "!", "&", "|":                r = CLS_LOGICAL;
      "(", ")", "[", "]", "{", "}": r = CLS_BRACKET;
      ",", ";":                     r = CLS_SEPARATOR;
      default:                      r = CLS_ERROR;
    endcase
    return r;
  endfunction

  function automatic logic pairs_with(input logic [7:0] first, input logic [7:0] c);
    logic r;
    case (first) inside
      "+":           r = (c == "+");
      "-":           r = (c == "-");
      "<", ">", "!": r = (c == "=");
      "&":           r = (c == "&");
      "|":           r = (c == "|");
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  // hit flag over keyword index, first match wins
  function automatic logic [4:0] kw_lookup(input logic [63:0] text);
    logic [4:0] r;
    r = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (text == KW_TEXT[k]) begin
        r = {1'b1, 4'(k)};
      end
    end
    return r;
  endfunction

  function automatic token_t single_token(input logic [7:0] c);
    token_t r;
    r = '0;
    r.tclass = single_class(c);
    r.text = 64'(c);
    r.len = 6'd1;
    return r;
  endfunction

  function automatic token_t pair_token(input logic [7:0] first, input logic [7:0] c);
    token_t r;
    r = '0;
    r.tclass = (first == "!") ? CLS_RELATION : single_class(first);
    r.text = {48'h0, c, first};
    r.len = 6'd2;
    return r;
  endfunction

endpackage

// File: rtl/cll_scan.sv
`include "assert_macros.svh"

module cll_scan #(
  parameter int TEXT_BYTES = 8,
  parameter int COUNTER_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      char_in,
  input  logic            end_of_text,
  output cll_pkg::token_t tok0,
  output cll_pkg::token_t tok1,
  output logic            tok0_valid,
  output logic            tok1_valid
);

  localparam int IW = $clog2(TEXT_BYTES);
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);
  localparam logic [5:0] LEN_MAX = 6'd63;
  localparam logic [5:0] LEN_KEEP = 6'(TEXT_BYTES);

  cll_pkg::mode_t mode, mode_next;
  logic [TEXT_BYTES-1:0][7:0] textbuf, textbuf_next;
  logic [5:0] len, len_next;
  logic ovf, ovf_next;
  logic [7:0] pend, pend_next;
  logic [COUNTER_BITS-1:0] line, line_next;
  logic [COUNTER_BITS-1:0] pos, pos_next;

  logic used, newline;
  logic a_valid, b_valid;
  cll_pkg::token_t a_tok, b_tok;
  logic [COUNTER_BITS-1:0] pos_a, pos_b;

  function automatic logic [15:0] sat16(input logic [COUNTER_BITS-1:0] v);
    return (v > COUNTER_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic logic [COUNTER_BITS-1:0] inc(input logic [COUNTER_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

  function automatic cll_pkg::token_t run_token(input logic is_word,
                                                input logic [TEXT_BYTES*8-1:0] t,
                                                input logic [5:0] l,
                                                input logic o);
    cll_pkg::token_t r;
    logic [4:0] hit;
    r = '0;
    hit = cll_pkg::kw_lookup(64'(t));
    r.tclass = cll_pkg::CLS_NUMBER;
    if (is_word) begin
      r.tclass = cll_pkg::CLS_IDENT;
      // an overlong word never matches a keyword
      if (!o && hit[4]) begin
        r.tclass = cll_pkg::CLS_KEYWORD;
        r.kw = hit[3:0];
      end
    end
    r.text = 64'(t);
    r.len = l;
    r.too_long = o;
    return r;
  endfunction

  always_comb begin
    mode_next = mode;
    textbuf_next = textbuf;
    len_next = len;
    ovf_next = ovf;
    pend_next = pend;
    used = 1'b0;
    newline = 1'b0;
    a_valid = 1'b0;
    a_tok = '0;
    b_valid = 1'b0;
    b_tok = '0;

    // close or extend what the previous bytes left open
    case (mode)
      cll_pkg::MODE_NUM: begin
        if (cll_pkg::is_digit(char_in)) begin
          used = 1'b1;
        end else begin
          a_valid = 1'b1;
          a_tok = run_token(1'b0, textbuf, len, ovf);
          mode_next = cll_pkg::MODE_IDLE;
          textbuf_next = '0;
          len_next = '0;
          ovf_next = 1'b0;
        end
      end
      cll_pkg::MODE_WORD: begin
        if (cll_pkg::is_letter(char_in) || cll_pkg::is_digit(char_in)) begin
          used = 1'b1;
        end else begin
          a_valid = 1'b1;
          a_tok = run_token(1'b1, textbuf, len, ovf);
          mode_next = cll_pkg::MODE_IDLE;
          textbuf_next = '0;
          len_next = '0;
          ovf_next = 1'b0;
        end
      end
      cll_pkg::MODE_SYM: begin
        a_valid = 1'b1;
        if (cll_pkg::pairs_with(pend, char_in)) begin
          used = 1'b1;
          a_tok = cll_pkg::pair_token(pend, char_in);
        end else begin
          a_tok = cll_pkg::single_token(pend);
        end
        pend_next = '0;
        mode_next = cll_pkg::MODE_IDLE;
      end
      default: begin
      end
    endcase

    // append to a running number or word
    if (used && (mode != cll_pkg::MODE_SYM)) begin
      if (len < LEN_KEEP) begin
        textbuf_next[len[IW-1:0]] = char_in;
      end else begin
        ovf_next = 1'b1;
      end
      if (len != LEN_MAX) begin
        len_next = len + 6'd1;
      end
    end

    // byte starts something new
    if (!used) begin
      if (char_in == cll_pkg::CH_NEWLINE) begin
        newline = 1'b1;
      end else if (char_in == cll_pkg::CH_SPACE) begin
      end else if (cll_pkg::is_digit(char_in) || cll_pkg::is_letter(char_in)) begin
        textbuf_next = '0;
        textbuf_next[0] = char_in;
        len_next = 6'd1;
        ovf_next = 1'b0;
        mode_next = cll_pkg::is_digit(char_in) ? cll_pkg::MODE_NUM : cll_pkg::MODE_WORD;
      end else if (cll_pkg::is_sym_start(char_in)) begin
        pend_next = char_in;
        mode_next = cll_pkg::MODE_SYM;
      end else begin
        b_valid = 1'b1;
        b_tok = cll_pkg::single_token(char_in);
      end
    end

    // flush at end of text
    if (end_of_text) begin
      case (mode_next)
        cll_pkg::MODE_NUM: begin
          b_valid = 1'b1;
          b_tok = run_token(1'b0, textbuf_next, len_next, ovf_next);
        end
        cll_pkg::MODE_WORD: begin
          b_valid = 1'b1;
          b_tok = run_token(1'b1, textbuf_next, len_next, ovf_next);
        end
        cll_pkg::MODE_SYM: begin
          b_valid = 1'b1;
          b_tok = cll_pkg::single_token(pend_next);
        end
        default: begin
        end
      endcase
      mode_next = cll_pkg::MODE_IDLE;
      textbuf_next = '0;
      len_next = '0;
      ovf_next = 1'b0;
      pend_next = '0;
    end

    pos_a = a_valid ? inc(pos) : pos;
    pos_b = b_valid ? inc(pos_a) : pos_a;
    pos_next = newline ? CNT_ONE : pos_b;
    line_next = newline ? inc(line) : line;

    tok0_valid = take && (a_valid || b_valid);
    tok1_valid = take && a_valid && b_valid;

    tok0 = a_valid ? a_tok : b_tok;
    tok0.line = sat16(line);
    tok0.pos = sat16(pos);
    tok0.last = !(a_valid && b_valid);

    tok1 = b_tok;
    tok1.line = sat16(line);
    tok1.pos = sat16(pos_a);
    tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cll_pkg::MODE_IDLE;
      textbuf <= '0;
      len <= '0;
      ovf <= 1'b0;
      pend <= '0;
      line <= CNT_ONE;
      pos <= CNT_ONE;
    end else if (take) begin
      mode <= mode_next;
      textbuf <= textbuf_next;
      len <= len_next;
      ovf <= ovf_next;
      pend <= pend_next;
      line <= line_next;
      pos <= pos_next;
    end
  end

  `ASSERT_CHK(a_sym_pending, (mode == cll_pkg::MODE_SYM) |-> cll_pkg::is_sym_start(pend), "bad pending symbol")
  `ASSERT_CHK(a_run_nonempty, ((mode == cll_pkg::MODE_NUM) || (mode == cll_pkg::MODE_WORD)) |-> (len != 6'd0), "empty run")
  `ASSERT_CHK(a_flush_idle, (take && end_of_text) |=> (mode == cll_pkg::MODE_IDLE), "no flush at end")
  `ASSERT_CHK(a_second_last, tok1_valid |-> (tok0_valid && !tok0.last), "second word order")
  `ASSERT_CHK(a_line_start, (take && (char_in == cll_pkg::CH_NEWLINE) && !used) |=> (pos == CNT_ONE), "position not restarted")

endmodule

// File: rtl/cll_queue.sv
`include "assert_macros.svh"

module cll_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push0,
  input  logic            push1,
  input  cll_pkg::token_t din0,
  input  cll_pkg::token_t din1,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output cll_pkg::token_t dout
);

  localparam int QIW = $clog2(cll_pkg::QUEUE_DEPTH);
  localparam logic [QIW:0] DEPTH = (QIW + 1)'(cll_pkg::QUEUE_DEPTH);

  cll_pkg::token_t mem [cll_pkg::QUEUE_DEPTH];
  logic [QIW-1:0] wr_ptr, wr_ptr_next;
  logic [QIW-1:0] rd_ptr, rd_ptr_next;
  logic [QIW:0] count, count_next;
  logic [QIW-1:0] wr_ptr_plus;
  logic pop;

  always_comb begin
    pop = out_valid && !out_stall;
    wr_ptr_plus = wr_ptr + QIW'(1);
    wr_ptr_next = wr_ptr + QIW'(push0) + QIW'(push1);
    rd_ptr_next = rd_ptr + QIW'(pop);
    count_next = count + (QIW + 1)'(push0) + (QIW + 1)'(push1) - (QIW + 1)'(pop);
    room = count <= (DEPTH - (QIW + 1)'(2));
    out_valid = count != '0;
    dout = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= din0;
    end
    if (push1) begin
      mem[wr_ptr_plus] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count <= count_next;
    end
  end

  `ASSERT_CHK(a_count_bound, count <= DEPTH, "queue overfilled")
  `ASSERT_CHK(a_push_room, (count > (DEPTH - (QIW + 1)'(2))) |-> !push0, "push without room")
  `ASSERT_CHK(a_pair_push, push1 |-> push0, "second word pushed alone")
  `ASSERT_CHK(a_drain, (pop && !push0) |=> (count == ($past(count) - (QIW + 1)'(1))), "count lost")

endmodule

// File: rtl/c_like_lexer.sv
// c_like_lexer: byte-serial lexer for a small c-like language
// input channel: one source byte a word on char_in, end_of_text high on the
//   final byte of a text; taken when in_valid is high and in_stall is low
// output channel: one token a word (class, keyword index, first bytes of text,
//   length, overlong flag, line, ordinal in line, last_of_run); taken when
//   out_valid is high and out_stall is low
// a byte gives zero, one or two tokens; last_of_run marks the final one
// a token closed by a byte is queued when that byte is taken; a pending token
//   leaves only when a later byte or end_of_text ends it
// throughput: one byte per cycle while the receiver keeps up; the tokens wait
//   in a four-word queue and in_stall rises when fewer than two places are
//   free, so a byte giving two tokens queues both and slows only the output
// reset (rst, synchronous): queue empties, scanner returns to idle, line and
//   ordinal counters go back to 1
// while out_stall is high the head token holds; bytes are still taken until
//   fewer than two places are free in the queue
module c_like_lexer #(
  parameter int TEXT_BYTES = 8,
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_class,
  output logic [3:0]  keyword_number,
  output logic [63:0] token_text,
  output logic [5:0]  token_length,
  output logic        too_long,
  output logic [15:0] line_number,
  output logic [15:0] token_position,
  output logic        last_of_run
);

  logic take, room;
  logic tok0_valid, tok1_valid;
  cll_pkg::token_t tok0, tok1, head;

  assign in_stall = !room;
  assign take = in_valid && room;

  cll_scan #(
    .TEXT_BYTES(TEXT_BYTES),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .take(take),
    .char_in(char_in),
    .end_of_text(end_of_text),
    .tok0(tok0),
    .tok1(tok1),
    .tok0_valid(tok0_valid),
    .tok1_valid(tok1_valid)
  );

  cll_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push0(tok0_valid),
    .push1(tok1_valid),
    .din0(tok0),
    .din1(tok1),
    .room(room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dout(head)
  );

  assign token_class = head.tclass;
  assign keyword_number = head.kw;
  assign token_text = head.text;
  assign token_length = head.len;
  assign too_long = head.too_long;
  assign line_number = head.line;
  assign token_position = head.pos;
  assign last_of_run = head.last;

endmodule
